/* rtl/datt_pkg.sv */
// datt_pkg: shared constants of the dram access timing tracker
// field and state widths, opcodes, register indexes, row policies, reset values and parameter defaults
// no dependencies
package datt_pkg;

	// item field widths
	localparam int OPCODE_W = 2;
	localparam int ADDR_W   = 40;
	localparam int BYTES_W  = 20;
	localparam int ACC_W    = 13;
	localparam int STALL_W  = 48;
	localparam int CHAN_W   = 8;
	localparam int BANK_W   = 8;
	localparam int ROW_W    = 22;

	// state widths
	localparam int CYCLE_W   = 48;
	localparam int BUDGET_W  = 24;
	localparam int PENDING_W = 32;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int LAT_W      = 10;
	localparam int PENALTY_W  = 12;
	localparam int POLICY_W   = 2;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_READ   = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_WRITE  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IDEAL_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_READ_LATENCY   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_LATENCY  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_POLICY     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEGACY_READ    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MISS_PENALTY   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ADDR_MAPPING   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BUDGET  = 3'd7;

	// row policies, the unused code behaves as legacy
	localparam logic [POLICY_W-1:0] POLICY_LEGACY = 2'd0;
	localparam logic [POLICY_W-1:0] POLICY_OPEN   = 2'd1;
	localparam logic [POLICY_W-1:0] POLICY_CLOSED = 2'd2;

	// register reset values
	localparam logic [LAT_W-1:0]     RST_READ_LATENCY  = 10'd50;
	localparam logic [LAT_W-1:0]     RST_WRITE_LATENCY = 10'd50;
	localparam logic [PENALTY_W-1:0] RST_MISS_PENALTY  = 12'd10;
	localparam logic [BUDGET_W-1:0]  RST_WINDOW_BUDGET = 24'd256000;

	// parameter defaults
	localparam int DEF_CHANNELS    = 8;
	localparam int DEF_BANKS       = 16;
	localparam int DEF_BURST_BYTES = 64;
	localparam int DEF_ROW_BYTES   = 2048;
	localparam int DEF_WIN_LEN     = 1000;

endpackage

/* rtl/datt_cmd_if.sv */
// datt_cmd_if: request channel of the timing tracker, valid/ready plus payload
// depends on datt_pkg for field widths
interface datt_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [datt_pkg::OPCODE_W-1:0] opcode;
	logic [datt_pkg::ADDR_W-1:0]   address;
	logic [datt_pkg::BYTES_W-1:0]  byte_count;

	modport source (output valid, opcode, address, byte_count, input ready);
	modport sink (input valid, opcode, address, byte_count, output ready);
endinterface

/* rtl/datt_rsp_if.sv */
// datt_rsp_if: result channel of the timing tracker, valid/ready plus payload
// depends on datt_pkg for field widths
interface datt_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [datt_pkg::ACC_W-1:0]   access_cycles;
	logic [datt_pkg::STALL_W-1:0] stall_cycles;
	logic [datt_pkg::CHAN_W-1:0]  channel_index;
	logic [datt_pkg::BANK_W-1:0]  bank_index;
	logic [datt_pkg::ROW_W-1:0]   row_index;
	logic                         row_hit;
	logic                         row_conflict;

	modport source (output valid, access_cycles, stall_cycles, channel_index, bank_index,
		row_index, row_hit, row_conflict, input ready);
	modport sink (input valid, access_cycles, stall_cycles, channel_index, bank_index,
		row_index, row_hit, row_conflict, output ready);
endinterface

/* rtl/dram_access_timing_tracker_core.sv */
// dram_access_timing_tracker_core: per-access dram latency, row and bandwidth stall tracking
// depends on datt_pkg, datt_cmd_if and datt_rsp_if
//
//   channel   dir  handshake          carries
//   cmd       in   valid/ready        opcode, address, byte_count
//   rsp       out  valid/ready        access_cycles, stall_cycles, channel/bank/row, hit, conflict
//   cfg       in   cfg_we             cfg_index, cfg_data (write only)
//
// one item per cycle sustained while rsp keeps up; a read or write goes through stage 1
// and then the result register (decode and open-row memory read at accept, timing update
// in stage 1, result register loaded as stage 1 leaves)
// ticks and unused opcodes yield no result and never wait on rsp
// a stalled rsp holds stage 1 only when it carries a read or write
// reset clears all counters, channel ready times and open-row valid flops at once
module dram_access_timing_tracker_core #(
	parameter int CHANNELS    = datt_pkg::DEF_CHANNELS,
	parameter int BANKS       = datt_pkg::DEF_BANKS,
	parameter int BURST_BYTES = datt_pkg::DEF_BURST_BYTES,
	parameter int ROW_BYTES   = datt_pkg::DEF_ROW_BYTES,
	parameter int WIN_LEN     = datt_pkg::DEF_WIN_LEN
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [datt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [datt_pkg::CFG_DATA_W-1:0] cfg_data,
	datt_cmd_if.sink                        cmd,
	datt_rsp_if.source                      rsp
);

	localparam int AW        = datt_pkg::ADDR_W;
	localparam int CW        = datt_pkg::CYCLE_W;
	localparam int LBU       = $clog2(BURST_BYTES);
	localparam int BPR       = (ROW_BYTES / BURST_BYTES == 0) ? 1 : ROW_BYTES / BURST_BYTES;
	localparam int LBPR      = $clog2(BPR);
	localparam int LC        = $clog2(CHANNELS);
	localparam int LBK       = $clog2(BANKS);
	localparam int DEPTH     = CHANNELS * BANKS;
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CHI_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ELAPSED_W = $clog2(WIN_LEN + 1);

	// configuration registers
	logic                             ideal_q;
	logic [datt_pkg::LAT_W-1:0]       rd_lat_q;
	logic [datt_pkg::LAT_W-1:0]       wr_lat_q;
	logic [datt_pkg::POLICY_W-1:0]    policy_q;
	logic                             legacy_rd_q;
	logic [datt_pkg::PENALTY_W-1:0]   penalty_q;
	logic                             mapping_q;
	logic [datt_pkg::BUDGET_W-1:0]    win_budget_q;
	logic                             invalidate;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ideal_q      <= 1'b0;
			rd_lat_q     <= datt_pkg::RST_READ_LATENCY;
			wr_lat_q     <= datt_pkg::RST_WRITE_LATENCY;
			policy_q     <= datt_pkg::POLICY_LEGACY;
			legacy_rd_q  <= 1'b0;
			penalty_q    <= datt_pkg::RST_MISS_PENALTY;
			mapping_q    <= 1'b0;
			win_budget_q <= datt_pkg::RST_WINDOW_BUDGET;
		end else if (cfg_we) begin
			case (cfg_index)
				datt_pkg::REG_IDEAL_MODE:    ideal_q      <= cfg_data[0];
				datt_pkg::REG_READ_LATENCY:  rd_lat_q     <= cfg_data[datt_pkg::LAT_W-1:0];
				datt_pkg::REG_WRITE_LATENCY: wr_lat_q     <= cfg_data[datt_pkg::LAT_W-1:0];
				datt_pkg::REG_ROW_POLICY:    policy_q     <= cfg_data[datt_pkg::POLICY_W-1:0];
				datt_pkg::REG_LEGACY_READ:   legacy_rd_q  <= cfg_data[0];
				datt_pkg::REG_MISS_PENALTY:  penalty_q    <= cfg_data[datt_pkg::PENALTY_W-1:0];
				datt_pkg::REG_ADDR_MAPPING:  mapping_q    <= cfg_data[0];
				datt_pkg::REG_WINDOW_BUDGET: win_budget_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign invalidate = cfg_we && (cfg_index == datt_pkg::REG_ROW_POLICY ||
		cfg_index == datt_pkg::REG_MISS_PENALTY || cfg_index == datt_pkg::REG_ADDR_MAPPING);

	// address decode at accept, shifts and masks only
	logic [AW-1:0]    burst, rgrp, grp, chan, bank, rowg, idx_full;
	logic [IDX_W-1:0] cmd_idx;

	always_comb begin
		burst    = cmd.address >> LBU;
		rgrp     = burst >> LBPR;
		grp      = burst >> (LC + LBPR);
		chan     = (mapping_q ? rgrp : burst) & AW'(CHANNELS - 1);
		bank     = grp & AW'(BANKS - 1);
		rowg     = grp >> LBK;
		idx_full = (chan << LBK) | bank;
		cmd_idx  = idx_full[IDX_W-1:0];
	end

	// stage 1
	logic                          s1_v_q;
	logic [datt_pkg::OPCODE_W-1:0] op_s1;
	logic [datt_pkg::BYTES_W-1:0]  bytes_s1;
	logic [datt_pkg::CHAN_W-1:0]   ch_s1;
	logic [datt_pkg::BANK_W-1:0]   bk_s1;
	logic [datt_pkg::ROW_W-1:0]    row_s1;
	logic [IDX_W-1:0]              idx_s1;
	logic [datt_pkg::ROW_W-1:0]    rd_row_s1;
	logic                          cmd_acc, s1_go, is_read, is_access, row_wr;

	// result register
	logic                         rsp_v_q;
	logic [datt_pkg::ACC_W-1:0]   acc_s2;
	logic [datt_pkg::STALL_W-1:0] stall_s2;
	logic [datt_pkg::CHAN_W-1:0]  ch_s2;
	logic [datt_pkg::BANK_W-1:0]  bk_s2;
	logic [datt_pkg::ROW_W-1:0]   row_s2;
	logic                         hit_s2, conf_s2;

	assign is_read   = (op_s1 == datt_pkg::OP_READ);
	assign is_access = is_read || (op_s1 == datt_pkg::OP_WRITE);
	assign s1_go     = s1_v_q && (!is_access || !rsp_v_q || rsp.ready);
	assign cmd.ready = !s1_v_q || s1_go;
	assign cmd_acc   = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (cmd_acc) begin
			s1_v_q <= 1'b1;
		end else if (s1_go) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			op_s1    <= cmd.opcode;
			bytes_s1 <= cmd.byte_count;
			ch_s1    <= chan[datt_pkg::CHAN_W-1:0];
			bk_s1    <= bank[datt_pkg::BANK_W-1:0];
			row_s1   <= rowg[datt_pkg::ROW_W-1:0];
			idx_s1   <= cmd_idx;
		end
	end

	// open-row memory, valid bits kept in flops so reset and invalidation act at once
	logic [datt_pkg::ROW_W-1:0] row_mem [DEPTH];
	logic [DEPTH-1:0]           row_valid_q;

	always_ff @(posedge clk) begin
		if (row_wr) begin
			row_mem[idx_s1] <= row_s1;
		end
		if (cmd_acc) begin
			// forward a row written by the item leaving stage 1
			if (row_wr && idx_s1 == cmd_idx) begin
				rd_row_s1 <= row_s1;
			end else begin
				rd_row_s1 <= row_mem[cmd_idx];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (invalidate) begin
			row_valid_q <= '0;
		end else if (row_wr) begin
			row_valid_q[idx_s1] <= 1'b1;
		end
	end

	// timing state
	logic [CW-1:0]                   cycle_q;
	logic [ELAPSED_W-1:0]            elapsed_q;
	logic [datt_pkg::BUDGET_W-1:0]   budget_q;
	logic [datt_pkg::PENDING_W-1:0]  pending_q;
	logic [CW-1:0]                   ready_q [CHANNELS];

	logic                            pen, hit, conf;
	logic [datt_pkg::ACC_W-1:0]      lat;
	logic [CW:0]                     busy_diff;
	logic [CW-1:0]                   busy, ch_ready;
	logic                            over;
	logic [ELAPSED_W-1:0]            left, elapsed_inc;
	logic [CW:0]                     stall_sum;
	logic [datt_pkg::STALL_W-1:0]    stall;
	logic [datt_pkg::PENDING_W:0]    pend_sum;
	logic                            track;

	assign ch_ready = ready_q[ch_s1[CHI_W-1:0]];
	assign track    = s1_go && is_access && !ideal_q;

	always_comb begin
		pen    = 1'b0;
		hit    = 1'b0;
		row_wr = 1'b0;
		case (policy_q)
			datt_pkg::POLICY_CLOSED: pen = 1'b1;
			datt_pkg::POLICY_OPEN: begin
				if (row_valid_q[idx_s1] && rd_row_s1 == row_s1) begin
					hit = 1'b1;
				end else begin
					pen    = 1'b1;
					row_wr = track;
				end
			end
			default: pen = is_read && legacy_rd_q;
		endcase
		conf = pen;
		lat  = (is_read ? datt_pkg::ACC_W'(rd_lat_q) : datt_pkg::ACC_W'(wr_lat_q)) +
			(pen ? datt_pkg::ACC_W'(penalty_q) : '0);

		// channel busy wait, zero when the channel is already free
		busy_diff = {1'b0, ch_ready} - {1'b0, cycle_q};
		busy      = busy_diff[CW] ? '0 : busy_diff[CW-1:0];

		pend_sum  = {1'b0, pending_q} + (datt_pkg::PENDING_W + 1)'(bytes_s1);
		over      = pend_sum > (datt_pkg::PENDING_W + 1)'(budget_q);
		// elapsed stays below the window length, so the remainder is never negative
		left      = ELAPSED_W'(WIN_LEN) - elapsed_q;
		stall_sum = {1'b0, busy} + (over ? (CW + 1)'(left) : '0);
		stall     = stall_sum[CW] ? '1 : stall_sum[CW-1:0];

		elapsed_inc = elapsed_q + ELAPSED_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_q   <= '0;
			elapsed_q <= '0;
			budget_q  <= '0;
			pending_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				ready_q[i] <= '0;
			end
		end else if (s1_go && op_s1 == datt_pkg::OP_TICK) begin
			cycle_q <= cycle_q + CW'(1);
			if (elapsed_inc == ELAPSED_W'(WIN_LEN)) begin
				elapsed_q <= '0;
				budget_q  <= win_budget_q;
				pending_q <= '0;
			end else begin
				elapsed_q <= elapsed_inc;
			end
		end else if (track) begin
			ready_q[ch_s1[CHI_W-1:0]] <= cycle_q + CW'(lat);
			pending_q <= pend_sum[datt_pkg::PENDING_W] ? '1 : pend_sum[datt_pkg::PENDING_W-1:0];
			budget_q  <= (budget_q > datt_pkg::BUDGET_W'(bytes_s1)) ?
				budget_q - datt_pkg::BUDGET_W'(bytes_s1) : '0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (s1_go && is_access) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && is_access) begin
			if (ideal_q) begin
				acc_s2   <= '0;
				stall_s2 <= '0;
				ch_s2    <= '0;
				bk_s2    <= '0;
				row_s2   <= '0;
				hit_s2   <= 1'b0;
				conf_s2  <= 1'b0;
			end else begin
				acc_s2   <= lat;
				stall_s2 <= stall;
				ch_s2    <= ch_s1;
				bk_s2    <= bk_s1;
				row_s2   <= row_s1;
				hit_s2   <= hit;
				conf_s2  <= conf;
			end
		end
	end

	assign rsp.valid         = rsp_v_q;
	assign rsp.access_cycles = acc_s2;
	assign rsp.stall_cycles  = stall_s2;
	assign rsp.channel_index = ch_s2;
	assign rsp.bank_index    = bk_s2;
	assign rsp.row_index     = row_s2;
	assign rsp.row_hit       = hit_s2;
	assign rsp.row_conflict  = conf_s2;

`ifndef NO_ASSERTIONS
	a_elapsed_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		elapsed_q < ELAPSED_W'(WIN_LEN))
		else $error("window elapsed count reached the window length");

	a_row_fill_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(row_wr && !cfg_we) |=> row_valid_q[$past(idx_s1)])
		else $error("open-row fill did not mark its entry valid");

	a_hit_no_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.row_hit && rsp.row_conflict))
		else $error("result reports both row hit and row conflict");

	a_ideal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && ideal_q) |-> (rsp.access_cycles == '0 && rsp.stall_cycles == '0))
		else $error("ideal mode result carries nonzero timing");
`endif

endmodule

/* dv/tb_top.sv */
// tb_top: self-checking bench for dram_access_timing_tracker_core
// predicts decode, row penalty, channel busy and bandwidth stall for every access
// depends on datt_pkg, datt_cmd_if, datt_rsp_if and the core
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int OPCODE_W        = datt_pkg::OPCODE_W;
	localparam int ADDR_W          = datt_pkg::ADDR_W;
	localparam int BYTES_W         = datt_pkg::BYTES_W;
	localparam int ACC_W           = datt_pkg::ACC_W;
	localparam int STALL_W         = datt_pkg::STALL_W;
	localparam int CHAN_W          = datt_pkg::CHAN_W;
	localparam int BANK_W          = datt_pkg::BANK_W;
	localparam int ROW_W           = datt_pkg::ROW_W;
	localparam int CYCLE_W         = datt_pkg::CYCLE_W;
	localparam int BUDGET_W        = datt_pkg::BUDGET_W;
	localparam int PENDING_W       = datt_pkg::PENDING_W;
	localparam int CFG_IDX_W       = datt_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W      = datt_pkg::CFG_DATA_W;
	localparam int LAT_W           = datt_pkg::LAT_W;
	localparam int PENALTY_W       = datt_pkg::PENALTY_W;
	localparam int POLICY_W        = datt_pkg::POLICY_W;
	localparam int DEF_CHANNELS    = datt_pkg::DEF_CHANNELS;
	localparam int DEF_BANKS       = datt_pkg::DEF_BANKS;
	localparam int DEF_BURST_BYTES = datt_pkg::DEF_BURST_BYTES;
	localparam int DEF_ROW_BYTES   = datt_pkg::DEF_ROW_BYTES;

	localparam int IDLE_LIMIT  = 2000;
	localparam int ITEM_TARGET = 450;
	localparam logic [OPCODE_W-1:0] OP_UNUSED     = 2'd3;
	localparam logic [POLICY_W-1:0] POLICY_UNUSED = 2'd3;
	localparam logic [CYCLE_W-1:0]  WIN_LEN       = CYCLE_W'(datt_pkg::DEF_WIN_LEN);
	localparam longint unsigned ROW_BURSTS = (DEF_ROW_BYTES / DEF_BURST_BYTES == 0) ? 1 :
		DEF_ROW_BYTES / DEF_BURST_BYTES;
	localparam logic [63:0] STALL_MAX = 64'hFFFF_FFFF_FFFF;
	localparam logic [63:0] PEND_MAX  = 64'hFFFF_FFFF;

	typedef struct packed {
		logic [ACC_W-1:0]   acc;
		logic [STALL_W-1:0] stall;
		logic [CHAN_W-1:0]  chan;
		logic [BANK_W-1:0]  bank;
		logic [ROW_W-1:0]   row;
		logic               hit;
		logic               conflict;
	} timing_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	datt_cmd_if cmd_bus ();
	datt_rsp_if rsp_bus ();

	dram_access_timing_tracker_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_bus),
		.rsp       (rsp_bus)
	);

	// shadow registers
	logic                 m_ideal;
	logic [LAT_W-1:0]     m_rd_lat;
	logic [LAT_W-1:0]     m_wr_lat;
	logic [POLICY_W-1:0]  m_policy;
	logic                 m_legacy_rd;
	logic [PENALTY_W-1:0] m_penalty;
	logic                 m_map;
	logic [BUDGET_W-1:0]  m_budget_cfg;

	// shadow timing state
	logic [CYCLE_W-1:0]   cyc_cnt;
	logic [CYCLE_W-1:0]   win_start;
	logic [BUDGET_W-1:0]  budget_rem;
	logic [PENDING_W-1:0] pend_bytes;
	logic [CYCLE_W-1:0]   chan_ready [DEF_CHANNELS];
	logic                 open_valid [DEF_CHANNELS*DEF_BANKS];
	logic [ROW_W-1:0]     open_row [DEF_CHANNELS*DEF_BANKS];

	timing_t timing_q [$];
	int      fail_count  = 0;
	int      idle_cycles = 0;
	int      sent_items  = 0;
	bit      no_gaps     = 1'b0;

	always #5ns clk = ~clk;

	function automatic void drop_open_rows();
		for (int i = 0; i < DEF_CHANNELS*DEF_BANKS; i++) begin
			open_valid[i] = 1'b0;
			open_row[i]   = '0;
		end
	endfunction

	function automatic void model_reset();
		m_ideal      = 1'b0;
		m_rd_lat     = datt_pkg::RST_READ_LATENCY;
		m_wr_lat     = datt_pkg::RST_WRITE_LATENCY;
		m_policy     = datt_pkg::POLICY_LEGACY;
		m_legacy_rd  = 1'b0;
		m_penalty    = datt_pkg::RST_MISS_PENALTY;
		m_map        = 1'b0;
		m_budget_cfg = datt_pkg::RST_WINDOW_BUDGET;
		cyc_cnt      = '0;
		win_start    = '0;
		budget_rem   = '0;
		pend_bytes   = '0;
		for (int i = 0; i < DEF_CHANNELS; i++)
			chan_ready[i] = '0;
		drop_open_rows();
	endfunction

	function automatic void model_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			datt_pkg::REG_IDEAL_MODE:    m_ideal = data[0];
			datt_pkg::REG_READ_LATENCY:  m_rd_lat = data[LAT_W-1:0];
			datt_pkg::REG_WRITE_LATENCY: m_wr_lat = data[LAT_W-1:0];
			datt_pkg::REG_ROW_POLICY: begin
				m_policy = data[POLICY_W-1:0];
				drop_open_rows();
			end
			datt_pkg::REG_LEGACY_READ:   m_legacy_rd = data[0];
			datt_pkg::REG_MISS_PENALTY: begin
				m_penalty = data[PENALTY_W-1:0];
				drop_open_rows();
			end
			datt_pkg::REG_ADDR_MAPPING: begin
				m_map = data[0];
				drop_open_rows();
			end
			datt_pkg::REG_WINDOW_BUDGET: m_budget_cfg = data[BUDGET_W-1:0];
			default: ;
		endcase
	endfunction

	// refill budget once a full window has elapsed, modulo the counter width
	function automatic void refresh_window();
		logic [CYCLE_W-1:0] el;
		el = cyc_cnt - win_start;
		if (el >= WIN_LEN) begin
			budget_rem = m_budget_cfg;
			win_start  = cyc_cnt;
			pend_bytes = '0;
		end
	endfunction

	function automatic void track_item(logic [OPCODE_W-1:0] op, logic [ADDR_W-1:0] addr,
		logic [BYTES_W-1:0] bytes);
		logic [63:0]        burst;
		logic [63:0]        grp;
		logic [63:0]        rgrp;
		logic [63:0]        row_full;
		logic [63:0]        stall;
		logic [63:0]        sum;
		logic [CYCLE_W-1:0] el;
		logic [ACC_W-1:0]   lat;
		int unsigned        ch;
		int unsigned        bk;
		int unsigned        slot;
		timing_t            r;
		r = '0;
		if (op == datt_pkg::OP_TICK) begin
			cyc_cnt = cyc_cnt + CYCLE_W'(1);
			refresh_window();
		end else if ((op == datt_pkg::OP_READ || op == datt_pkg::OP_WRITE) && m_ideal) begin
			timing_q.push_back(r);
		end else if (op == datt_pkg::OP_READ || op == datt_pkg::OP_WRITE) begin
			refresh_window();
			burst = 64'(addr) / 64'(DEF_BURST_BYTES);
			if (m_map) begin
				rgrp = burst / ROW_BURSTS;
				ch   = 32'(rgrp % 64'(DEF_CHANNELS));
				grp  = rgrp / 64'(DEF_CHANNELS);
			end else begin
				ch  = 32'(burst % 64'(DEF_CHANNELS));
				grp = (burst / 64'(DEF_CHANNELS)) / ROW_BURSTS;
			end
			bk       = 32'(grp % 64'(DEF_BANKS));
			row_full = grp / 64'(DEF_BANKS);
			r.chan   = CHAN_W'(ch);
			r.bank   = BANK_W'(bk);
			r.row    = row_full[ROW_W-1:0];

			lat = (op == datt_pkg::OP_READ) ? ACC_W'(m_rd_lat) : ACC_W'(m_wr_lat);
			if (m_policy == datt_pkg::POLICY_CLOSED) begin
				lat        = lat + ACC_W'(m_penalty);
				r.conflict = 1'b1;
			end else if (m_policy == datt_pkg::POLICY_OPEN) begin
				slot = ch * 32'(DEF_BANKS) + bk;
				if (open_valid[slot] && open_row[slot] == r.row) begin
					r.hit = 1'b1;
				end else begin
					open_valid[slot] = 1'b1;
					open_row[slot]   = r.row;
					lat              = lat + ACC_W'(m_penalty);
					r.conflict       = 1'b1;
				end
			end else if (op == datt_pkg::OP_READ && m_legacy_rd) begin
				lat        = lat + ACC_W'(m_penalty);
				r.conflict = 1'b1;
			end
			r.acc = lat;

			stall = '0;
			if (chan_ready[ch] > cyc_cnt)
				stall = 64'(chan_ready[ch] - cyc_cnt);
			if (64'(pend_bytes) + 64'(bytes) > 64'(budget_rem)) begin
				el = cyc_cnt - win_start;
				if (el < WIN_LEN)
					stall = stall + 64'(WIN_LEN - el);
			end
			if (stall > STALL_MAX)
				stall = STALL_MAX;
			r.stall = stall[STALL_W-1:0];

			chan_ready[ch] = cyc_cnt + CYCLE_W'(lat);
			sum        = 64'(pend_bytes) + 64'(bytes);
			pend_bytes = (sum > PEND_MAX) ? PEND_MAX[PENDING_W-1:0] : sum[PENDING_W-1:0];
			budget_rem = (budget_rem > BUDGET_W'(bytes)) ? budget_rem - BUDGET_W'(bytes) : '0;
			timing_q.push_back(r);
		end
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		timing_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (timing_q.size() == 0) begin
				$display("%0t ns: result expected none actual access_cycles %0d stall_cycles %0d",
					$time, rsp_bus.access_cycles, rsp_bus.stall_cycles);
				fail_count++;
			end else begin
				want = timing_q.pop_front();
				check_field("access_cycles", want.acc, rsp_bus.access_cycles);
				check_field("stall_cycles", want.stall, rsp_bus.stall_cycles);
				check_field("channel_index", want.chan, rsp_bus.channel_index);
				check_field("bank_index", want.bank, rsp_bus.bank_index);
				check_field("row_index", want.row, rsp_bus.row_index);
				check_field("row_hit", want.hit, rsp_bus.row_hit);
				check_field("row_conflict", want.conflict, rsp_bus.row_conflict);
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("dram_access_timing_tracker_core: mismatch");
			$finish;
		end
	end

	always @(negedge clk)
		rsp_bus.ready <= no_gaps || ($urandom_range(99, 0) >= 13);

	// one item per call, entered and left on a falling edge; valid stays up afterwards
	task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [ADDR_W-1:0] addr,
		input logic [BYTES_W-1:0] bytes);
		while (!no_gaps && $urandom_range(99, 0) < 13) begin
			cmd_bus.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_bus.valid      <= 1'b1;
		cmd_bus.opcode     <= op;
		cmd_bus.address    <= addr;
		cmd_bus.byte_count <= bytes;
		@(posedge clk);
		while (!cmd_bus.ready)
			@(posedge clk);
		track_item(op, addr, bytes);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic send_ticks(input int n);
		repeat (n)
			send_item(datt_pkg::OP_TICK, ADDR_W'({$urandom, $urandom}), BYTES_W'($urandom));
	endtask

	task automatic wait_idle();
		cmd_bus.valid <= 1'b0;
		while (timing_q.size() != 0)
			@(negedge clk);
		// ticks still in the pipe give no result
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		model_config(idx, data);
		@(negedge clk);
	endtask

	// default geometry: bank in address bits 17:14, row above
	function automatic logic [ADDR_W-1:0] rand_addr();
		logic [ADDR_W-1:0] a;
		int unsigned       sel;
		a = ADDR_W'({$urandom, $urandom});
		if ($urandom_range(99, 0) < 75) begin
			sel = $urandom_range(3, 0);
			a[ADDR_W-1:18] = (sel == 3) ? '1 : 22'(sel);
			a[17:14]       = 4'($urandom_range(3, 0));
		end
		return a;
	endfunction

	function automatic logic [BYTES_W-1:0] rand_bytes();
		case ($urandom_range(7, 0))
			0: return '0;
			1, 2, 3, 4: return BYTES_W'($urandom_range(256, 1));
			5, 6: return BYTES_W'($urandom);
			default: return '1;
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_value(int width);
		logic [CFG_DATA_W-1:0] mask;
		mask = (CFG_DATA_W'(1) << width) - 1'b1;
		if (width >= CFG_DATA_W)
			mask = '1;
		case ($urandom_range(3, 0))
			0: return '0;
			1: return mask;
			default: return CFG_DATA_W'($urandom) & mask;
		endcase
	endfunction

	// junk above the register width must be dropped by the block
	function automatic logic [CFG_DATA_W-1:0] with_noise(int width, logic [CFG_DATA_W-1:0] value);
		logic [CFG_DATA_W-1:0] n;
		n = CFG_DATA_W'($urandom);
		n = n << width;
		return n | value;
	endfunction

	task automatic test_reset_defaults();
		send_item(datt_pkg::OP_READ, '0, '0);
		send_item(datt_pkg::OP_WRITE, '1, '1);
	endtask

	task automatic test_legacy_policy();
		cfg_write(datt_pkg::REG_LEGACY_READ, 1);
		send_item(datt_pkg::OP_READ, 40'h00_0004_0040, 20'd64);
		send_item(datt_pkg::OP_WRITE, 40'h00_0004_0040, 20'd64);
		cfg_write(datt_pkg::REG_ROW_POLICY, POLICY_UNUSED);
		send_item(datt_pkg::OP_READ, 40'h12_3456_789a, 20'd1);
		cfg_write(datt_pkg::REG_LEGACY_READ, 0);
		cfg_write(datt_pkg::REG_ROW_POLICY, datt_pkg::POLICY_LEGACY);
	endtask

	task automatic test_open_page();
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] b;
		a = 40'h00_0040_4080;
		b = a + (40'd1 << 18);
		cfg_write(datt_pkg::REG_ROW_POLICY, datt_pkg::POLICY_OPEN);
		send_item(datt_pkg::OP_READ, a, 20'd32);
		send_item(datt_pkg::OP_READ, a, 20'd32);
		send_item(datt_pkg::OP_WRITE, b, 20'd32);
		send_item(datt_pkg::OP_READ, a, 20'd32);
		// penalty and mapping writes flush the open rows
		cfg_write(datt_pkg::REG_MISS_PENALTY, '1);
		send_item(datt_pkg::OP_READ, a, 20'd8);
		send_item(datt_pkg::OP_READ, a, 20'd8);
		cfg_write(datt_pkg::REG_ADDR_MAPPING, 1);
		send_item(datt_pkg::OP_WRITE, a, 20'd8);
		cfg_write(datt_pkg::REG_ADDR_MAPPING, 0);
	endtask

	task automatic test_closed_page();
		cfg_write(datt_pkg::REG_ROW_POLICY, datt_pkg::POLICY_CLOSED);
		cfg_write(datt_pkg::REG_READ_LATENCY, '1);
		cfg_write(datt_pkg::REG_WRITE_LATENCY, '0);
		send_item(datt_pkg::OP_READ, 40'h00_0000_0080, 20'd16);
		send_item(datt_pkg::OP_WRITE, 40'h00_0000_0080, 20'd16);
	endtask

	task automatic test_channel_busy();
		// same channel back to back, each read waits on the one before
		no_gaps = 1'b1;
		send_item(datt_pkg::OP_READ, 40'h00_0000_00c0, 20'd4);
		send_item(datt_pkg::OP_READ, 40'h00_0000_40c0, 20'd4);
		send_ticks(1);
		send_item(datt_pkg::OP_READ, 40'h00_0008_00c0, 20'd4);
		no_gaps = 1'b0;
	endtask

	task automatic test_unused_opcode();
		send_item(OP_UNUSED, '1, '1);
		send_ticks(2);
		send_item(OP_UNUSED, '0, '0);
		send_item(datt_pkg::OP_WRITE, 40'h00_0100_0000, 20'd2);
	endtask

	task automatic test_ideal_mode();
		cfg_write(datt_pkg::REG_IDEAL_MODE, 1);
		send_item(datt_pkg::OP_READ, 40'h55_5555_5555, 20'd100);
		send_item(datt_pkg::OP_WRITE, 40'haa_aaaa_aaaa, 20'd100);
		send_ticks(3);
		cfg_write(datt_pkg::REG_IDEAL_MODE, 0);
		send_item(datt_pkg::OP_READ, 40'h55_5555_5555, 20'd100);
	endtask

	task automatic test_bandwidth_stall();
		// the first window is still open, so the budget is empty and bytes wait out the window
		cfg_write(datt_pkg::REG_WINDOW_BUDGET, 100);
		send_ticks(20);
		send_item(datt_pkg::OP_READ, 40'h00_0000_0000, 20'd0);
		send_item(datt_pkg::OP_READ, 40'h00_0000_0040, 20'd60);
		send_item(datt_pkg::OP_WRITE, 40'h00_0000_0080, 20'd1);
		send_ticks(5);
		send_item(datt_pkg::OP_WRITE, 40'h00_0000_0140, '1);
		cfg_write(datt_pkg::REG_WINDOW_BUDGET, '0);
	endtask

	task automatic randomize_config(input int phase);
		logic [CFG_DATA_W-1:0] policy;
		logic [CFG_DATA_W-1:0] budget;
		policy = ($urandom_range(1, 0) || phase == 0) ? CFG_DATA_W'(datt_pkg::POLICY_OPEN) :
			CFG_DATA_W'($urandom_range(3, 0));
		case ($urandom_range(3, 0))
			0: budget = pick_value(BUDGET_W);
			1: budget = CFG_DATA_W'($urandom_range(3000, 0));
			2: budget = CFG_DATA_W'($urandom_range(300000, 3000));
			default: budget = '1;
		endcase
		cfg_write(datt_pkg::REG_IDEAL_MODE,
			with_noise(1, (phase == 1) || ($urandom_range(9, 0) == 0)));
		cfg_write(datt_pkg::REG_READ_LATENCY, with_noise(LAT_W, pick_value(LAT_W)));
		cfg_write(datt_pkg::REG_WRITE_LATENCY, with_noise(LAT_W, pick_value(LAT_W)));
		cfg_write(datt_pkg::REG_ROW_POLICY, with_noise(POLICY_W, policy));
		cfg_write(datt_pkg::REG_LEGACY_READ, with_noise(1, $urandom_range(1, 0)));
		cfg_write(datt_pkg::REG_MISS_PENALTY, with_noise(PENALTY_W, pick_value(PENALTY_W)));
		cfg_write(datt_pkg::REG_ADDR_MAPPING, with_noise(1, $urandom_range(1, 0)));
		cfg_write(datt_pkg::REG_WINDOW_BUDGET, budget);
	endtask

	task automatic test_random_traffic();
		int kind;
		for (int phase = 0; sent_items < ITEM_TARGET; phase++) begin
			randomize_config(phase);
			no_gaps = (phase == 2);
			for (int k = 0; k < 75 && sent_items < ITEM_TARGET; k++) begin
				kind = $urandom_range(99, 0);
				if (kind < 6)
					send_item(OP_UNUSED, rand_addr(), rand_bytes());
				else if (kind < 30)
					send_ticks(($urandom_range(19, 0) == 0) ? $urandom_range(30, 10) :
						$urandom_range(4, 1));
				else
					send_item((kind < 65) ? datt_pkg::OP_READ : datt_pkg::OP_WRITE, rand_addr(),
						rand_bytes());
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		cmd_bus.valid      = 1'b0;
		cmd_bus.opcode     = datt_pkg::OP_TICK;
		cmd_bus.address    = '0;
		cmd_bus.byte_count = '0;
		rsp_bus.ready      = 1'b0;
		model_reset();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_legacy_policy();
		test_open_page();
		test_closed_page();
		test_channel_busy();
		test_unused_opcode();
		test_ideal_mode();
		test_bandwidth_stall();
		test_random_traffic();

		wait_idle();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("dram_access_timing_tracker_core: match");
		else
			$display("dram_access_timing_tracker_core: mismatch");
		$finish;
	end

endmodule

/* filelist.f */
rtl/datt_pkg.sv
rtl/datt_cmd_if.sv
rtl/datt_rsp_if.sv
rtl/dram_access_timing_tracker_core.sv
dv/tb_top.sv
